FILE: rtl/rob_pkg.sv
// Shared types and constants for the in-order result reorder buffer.
`default_nettype none

package rob_pkg;

  localparam int unsigned SeqW    = 32;
  localparam int unsigned CountW  = 32;
  localparam int unsigned StrideW = 8;

  typedef struct packed {
    logic [SeqW-1:0]   seq;
    logic [CountW-1:0] count;
  } entry_t;

  typedef struct packed {
    logic eq;
    logic lt;
  } alu_flags_t;

endpackage

`default_nettype wire

FILE: rtl/in_order_result_reorder_buffer.sv
// Top level of the in-order result reorder buffer: sequencer, store and shared unit.
//
// Usage: a completed result (seq_num_i, count_value_i, end_known_i, end_seq_i)
// is transferred at a rising clock edge where start is high and busy is low.
// busy stays high until every result caused by that transfer has been shown.
// A result whose sequence number matches the expected number is released,
// followed by any stored results that continue the sequence; each release
// advances the expected number by seq_stride. Other results are inserted
// into a sorted circular store of CAPACITY entries; when it is full the
// result comes back once with dropped_o set.
// Each output transfer is on the out_* ports for exactly one cycle, marked
// by out_valid_o; the receiver cannot hold it off. last_of_run_o marks the
// final transfer of a run and all_done_o sits on that same transfer.
// Steps from the accept edge until busy falls: an in-order result passes
// the check, drains the stored entries that continue the sequence, looks
// once more at the store front when the store still holds entries after
// the drain, and ends with the final release. A drop leaves from the check.
// An insertion scans for its place, shifts any later entries up and then
// writes; the single read and single write port of the store move one entry per cycle.
// seq_stride must be written through seq_stride_we_i only while idle; the block does not enforce this.
// Reset clears the expected number, the stride (to 1) and the fill count;
// the store contents are not cleared, since entries past the fill count
// are never read.
`default_nettype none

module in_order_result_reorder_buffer import rob_pkg::*; #(
  parameter int unsigned CAPACITY = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [SeqW-1:0]    seq_num_i,
  input  wire logic [CountW-1:0]  count_value_i,
  input  wire logic               end_known_i,
  input  wire logic [SeqW-1:0]    end_seq_i,
  input  wire logic               seq_stride_we_i,
  input  wire logic [StrideW-1:0] seq_stride_i,
  output logic                    out_valid_o,
  output logic [SeqW-1:0]         out_seq_o,
  output logic [CountW-1:0]       out_count_o,
  output logic                    last_of_run_o,
  output logic                    all_done_o,
  output logic                    dropped_o
);

  localparam int unsigned AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam logic [CntW-1:0] CapCnt = CntW'(CAPACITY);

  // Sequencer states.
  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StCheck = 3'd1;
  localparam logic [2:0] StDrain = 3'd2;
  localparam logic [2:0] StFinal = 3'd3;
  localparam logic [2:0] StScan  = 3'd4;
  localparam logic [2:0] StShift = 3'd5;
  localparam logic [2:0] StWrite = 3'd6;

  logic [2:0]         state_q, state_d;
  logic [SeqW-1:0]    exp_q, exp_d;
  logic [StrideW-1:0] stride_q;
  logic [CntW-1:0]    total_q, total_d;
  logic [CntW-1:0]    idx_q, idx_d;
  logic [CntW-1:0]    j_q, j_d;
  logic [SeqW-1:0]    seq_q, seq_d;
  logic [CountW-1:0]  cnt_q, cnt_d;
  logic               end_known_q, end_known_d;
  logic [SeqW-1:0]    end_seq_q, end_seq_d;
  entry_t             pend_q, pend_d;

  // Shared unit operands and results.
  logic [SeqW-1:0] op_a, op_b, alu_sum;
  alu_flags_t      flags;

  // Store access.
  logic [CntW-1:0] rd_idx, wr_idx;
  logic            st_we, st_pop;
  entry_t          st_wdata, st_rdata;

  rob_alu u_alu (
    .op_a_i  (op_a),
    .op_b_i  (op_b),
    .inc_i   (stride_q),
    .flags_o (flags),
    .sum_o   (alu_sum)
  );

  rob_store #(
    .CAPACITY (CAPACITY),
    .AW       (AW)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_idx_i (rd_idx[AW-1:0]),
    .wr_idx_i (wr_idx[AW-1:0]),
    .we_i     (st_we),
    .wdata_i  (st_wdata),
    .pop_i    (st_pop),
    .rdata_o  (st_rdata)
  );

  // Operand selection: each state uses the one unit for its own question.
  always_comb begin
    case (state_q)
      StDrain: begin
        op_a = exp_q;
        op_b = st_rdata.seq;
      end
      StScan: begin
        op_a = st_rdata.seq;
        op_b = seq_q;
      end
      StFinal: begin
        op_a = exp_q;
        op_b = end_seq_q;
      end
      default: begin
        op_a = exp_q;
        op_b = seq_q;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    exp_d       = exp_q;
    total_d     = total_q;
    idx_d       = idx_q;
    j_d         = j_q;
    seq_d       = seq_q;
    cnt_d       = cnt_q;
    end_known_d = end_known_q;
    end_seq_d   = end_seq_q;
    pend_d      = pend_q;

    rd_idx   = '0;
    wr_idx   = '0;
    st_we    = 1'b0;
    st_pop   = 1'b0;
    st_wdata = st_rdata;

    out_valid_o   = 1'b0;
    out_seq_o     = pend_q.seq;
    out_count_o   = pend_q.count;
    last_of_run_o = 1'b0;
    all_done_o    = 1'b0;
    dropped_o     = 1'b0;

    case (state_q)
      StIdle: begin
        if (start) begin
          seq_d       = seq_num_i;
          cnt_d       = count_value_i;
          end_known_d = end_known_i;
          end_seq_d   = end_seq_i;
          state_d     = StCheck;
        end
      end

      StCheck: begin
        if (flags.eq) begin
          // In-order result: it becomes the pending release.
          pend_d.seq   = seq_q;
          pend_d.count = cnt_q;
          exp_d        = alu_sum;
          rd_idx       = '0;
          state_d      = (total_q == '0) ? StFinal : StDrain;
        end else if (total_q == CapCnt) begin
          // Store full: hand the result straight back as a drop.
          out_valid_o   = 1'b1;
          out_seq_o     = seq_q;
          out_count_o   = cnt_q;
          last_of_run_o = 1'b1;
          dropped_o     = 1'b1;
          state_d       = StIdle;
        end else begin
          idx_d   = '0;
          rd_idx  = '0;
          state_d = (total_q == '0) ? StWrite : StScan;
        end
      end

      StDrain: begin
        // The store front is in st_rdata; it continues the run only on a match.
        if (flags.eq) begin
          out_valid_o = 1'b1;
          pend_d      = st_rdata;
          exp_d       = alu_sum;
          st_pop      = 1'b1;
          total_d     = total_q - CntW'(1);
          rd_idx      = CntW'(1);
          if (total_q == CntW'(1)) begin
            state_d = StFinal;
          end
        end else begin
          state_d = StFinal;
        end
      end

      StFinal: begin
        out_valid_o   = 1'b1;
        last_of_run_o = 1'b1;
        all_done_o    = end_known_q && flags.eq;
        state_d       = StIdle;
      end

      StScan: begin
        // Walk forward while the stored number is below the new one.
        if (flags.lt) begin
          idx_d = idx_q + CntW'(1);
          if (idx_q + CntW'(1) == total_q) begin
            state_d = StWrite;
          end else begin
            rd_idx = idx_q + CntW'(1);
          end
        end else begin
          rd_idx  = total_q - CntW'(1);
          j_d     = total_q - CntW'(1);
          state_d = StShift;
        end
      end

      StShift: begin
        // Move entry j up by one while the entry below it is read.
        st_we    = 1'b1;
        wr_idx   = j_q + CntW'(1);
        st_wdata = st_rdata;
        if (j_q == idx_q) begin
          state_d = StWrite;
        end else begin
          rd_idx = j_q - CntW'(1);
          j_d    = j_q - CntW'(1);
        end
      end

      StWrite: begin
        st_we          = 1'b1;
        wr_idx         = idx_q;
        st_wdata.seq   = seq_q;
        st_wdata.count = cnt_q;
        total_d        = total_q + CntW'(1);
        state_d        = StIdle;
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign busy = (state_q != StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      exp_q    <= '0;
      total_q  <= '0;
      stride_q <= StrideW'(1);
    end else begin
      state_q <= state_d;
      exp_q   <= exp_d;
      total_q <= total_d;
      if (seq_stride_we_i) begin
        stride_q <= seq_stride_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    j_q         <= j_d;
    seq_q       <= seq_d;
    cnt_q       <= cnt_d;
    end_known_q <= end_known_d;
    end_seq_q   <= end_seq_d;
    pend_q      <= pend_d;
  end

  // The fill count never passes the capacity.
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= CapCnt)
    else $error("fill count exceeds capacity");

  // A drop is reported only when the store is full.
  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && dropped_o |-> total_q == CapCnt && last_of_run_o)
    else $error("drop reported with room in the store");

  // all_done only rides on the closing transfer of a run.
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    all_done_o |-> out_valid_o && last_of_run_o && !dropped_o)
    else $error("all_done outside the closing transfer");

  // An accepted item always keeps the block busy in the following cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted item did not start the sequencer");

endmodule

`default_nettype wire

FILE: rtl/rob_alu.sv
// Shared compare and increment unit used by the check, drain, final and scan steps of the sequencer.
`default_nettype none

module rob_alu import rob_pkg::*; (
  input  wire logic [SeqW-1:0]    op_a_i,
  input  wire logic [SeqW-1:0]    op_b_i,
  input  wire logic [StrideW-1:0] inc_i,
  output alu_flags_t              flags_o,
  output logic [SeqW-1:0]         sum_o
);

  // Unsigned compare of the two operands and a wrapping increment of op_a.
  assign flags_o.eq = (op_a_i == op_b_i);
  assign flags_o.lt = (op_a_i < op_b_i);
  assign sum_o      = op_a_i + SeqW'(inc_i);

endmodule

`default_nettype wire

FILE: rtl/rob_store.sv
// Circular entry store addressed by position relative to its front.
`default_nettype none

module rob_store import rob_pkg::*; #(
  parameter int unsigned CAPACITY = 32,
  parameter int unsigned AW       = 5
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [AW-1:0] rd_idx_i,
  input  wire logic [AW-1:0] wr_idx_i,
  input  wire logic          we_i,
  input  wire entry_t        wdata_i,
  input  wire logic          pop_i,
  output entry_t             rdata_o
);

  localparam logic [AW:0] CapW = (AW+1)'(CAPACITY);

  logic [AW-1:0] head_q, head_d;
  logic [AW-1:0] rd_phys, wr_phys;
  entry_t        mem_q [CAPACITY];
  entry_t        rdata_q;

  // Both operands are below the capacity, so one conditional subtract wraps.
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                             input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= CapW) begin
      sum = sum - CapW;
    end
    return sum[AW-1:0];
  endfunction

  assign rd_phys = wrap_add(head_q, rd_idx_i);
  assign wr_phys = wrap_add(head_q, wr_idx_i);
  assign head_d  = pop_i ? wrap_add(head_q, AW'(1)) : head_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
    end else begin
      head_q <= head_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wr_phys] <= wdata_i;
    end
    rdata_q <= mem_q[rd_phys];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
